FILE: sv/sfsf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the smallest-factor sieve factorizer.
// Used by sfsf_divider, sfsf_ctrl, sfsf_datapath and the top level.
package sfsf_pkg;

  localparam int N_W   = 16;
  localparam int I_W   = 9;
  localparam int J_W   = 17;
  localparam int TS_W  = 25;
  localparam int DC_W  = $clog2(N_W);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_INIT     = 10'b00_0000_0010,
    ST_SI_RD    = 10'b00_0000_0100,
    ST_SI_CHK   = 10'b00_0000_1000,
    ST_SJ_RD    = 10'b00_0001_0000,
    ST_SJ_UPD   = 10'b00_0010_0000,
    ST_Q_RD     = 10'b00_0100_0000,
    ST_DIV_GO   = 10'b00_1000_0000,
    ST_DIV_WAIT = 10'b01_0000_0000,
    ST_EMIT     = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic load;
    logic init_wr;
    logic i_rd;
    logic j_set;
    logic j_rd;
    logic j_upd;
    logic i_inc;
    logic q_rd;
    logic div_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_go;
    logic j_eq_n;
    logic i_sq_gt_n;
    logic i_prime;
    logic j_gt_n;
    logic div_done;
    logic q_le1;
  } sts_t;

endpackage

FILE: sv/sfsf_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on sfsf_pkg for the word width.
module sfsf_divider (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [sfsf_pkg::N_W-1:0] dividend,
  input  logic [sfsf_pkg::N_W-1:0] divisor,
  output logic                     done,
  output logic [sfsf_pkg::N_W-1:0] quotient,
  output logic [sfsf_pkg::N_W-1:0] remainder
);
  import sfsf_pkg::*;

  logic            run_r, run_nxt;
  logic            done_r, done_nxt;
  logic [DC_W-1:0] cnt_r, cnt_nxt;
  logic [N_W-1:0]  rem_r, rem_nxt;
  logic [N_W-1:0]  quo_r, quo_nxt;
  logic [N_W-1:0]  dvs_r, dvs_nxt;
  logic [N_W:0]    trial;
  logic [N_W:0]    diff;

  always_comb begin
    trial    = {rem_r, quo_r[N_W-1]};
    diff     = trial - {1'b0, dvs_r};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (run_r) begin
      if (!diff[N_W]) begin
        rem_nxt = diff[N_W-1:0];
        quo_nxt = {quo_r[N_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[N_W-1:0];
        quo_nxt = {quo_r[N_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DC_W'(N_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: sv/sfsf_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the factorizer: table fill, sieve passes, division loop.
// Depends on sfsf_pkg for state, command and status types.
module sfsf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  sfsf_pkg::sts_t sts,
  output sfsf_pkg::cmd_t cmd,
  output logic          busy
);
  import sfsf_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (sts.in_go) state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.j_eq_n) state_nxt = ST_SI_RD;
      end
      ST_SI_RD: begin
        if (sts.i_sq_gt_n) begin
          state_nxt = ST_Q_RD;
        end else begin
          cmd.i_rd  = 1'b1;
          state_nxt = ST_SI_CHK;
        end
      end
      ST_SI_CHK: begin
        if (sts.i_prime) begin
          cmd.j_set = 1'b1;
          state_nxt = ST_SJ_RD;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = ST_SI_RD;
        end
      end
      ST_SJ_RD: begin
        if (sts.j_gt_n) begin
          cmd.i_inc = 1'b1;
          state_nxt = ST_SI_RD;
        end else begin
          cmd.j_rd  = 1'b1;
          state_nxt = ST_SJ_UPD;
        end
      end
      ST_SJ_UPD: begin
        cmd.j_upd = 1'b1;
        state_nxt = ST_SJ_RD;
      end
      ST_Q_RD: begin
        cmd.q_rd  = 1'b1;
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = sts.q_le1 ? ST_IDLE : ST_Q_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && sts.q_le1 |=> state_r == ST_IDLE)
    else $error("last word did not end the item");

endmodule

FILE: sv/sfsf_datapath.sv
`timescale 1ns / 1ps
// Datapath of the factorizer: factor table, sieve counters, quotient, output.
// Depends on sfsf_pkg and sfsf_divider.
module sfsf_datapath #(
  parameter int TABLE_SIZE = 65536
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [sfsf_pkg::N_W-1:0] in_n_value,
  input  sfsf_pkg::cmd_t           cmd,
  output sfsf_pkg::sts_t           sts,
  output logic                     out_valid,
  output logic [sfsf_pkg::N_W-1:0] out_prime_factor,
  output logic                     out_last_factor
);
  import sfsf_pkg::*;

  localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  logic [N_W-1:0]   mem [TABLE_SIZE];
  logic [N_W-1:0]   rdata_r;
  logic [N_W-1:0]   n_r;
  logic [I_W-1:0]   i_r;
  logic [J_W-1:0]   j_r;
  logic [N_W-1:0]   q_r;
  logic [N_W-1:0]   f_r;
  logic             out_valid_r;
  logic [N_W-1:0]   out_pf_r;
  logic             out_last_r;
  logic [AW-1:0]    mem_addr;
  logic [N_W-1:0]   mem_wdata;
  logic             mem_we;
  logic             mem_re;
  logic             j_hit;
  logic [2*I_W-1:0] i_sq;
  logic             div_done;
  logic [N_W-1:0]   div_quo;
  logic [N_W-1:0]   div_rem;

  sfsf_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (q_r),
    .divisor   (rdata_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign j_hit = ({1'b0, rdata_r} == j_r);
  assign i_sq  = i_r * i_r;

  always_comb begin
    mem_addr  = AW'(j_r);
    mem_wdata = N_W'(j_r);
    if (cmd.i_rd) begin
      mem_addr = AW'(i_r);
    end else if (cmd.q_rd) begin
      mem_addr = AW'(q_r);
    end
    if (cmd.j_upd) mem_wdata = N_W'(i_r);
  end

  assign mem_we = cmd.init_wr | (cmd.j_upd & j_hit);
  assign mem_re = cmd.i_rd | cmd.j_rd | cmd.q_rd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r <= in_n_value;
      i_r <= I_W'(2);
      j_r <= J_W'(2);
      if (sts.in_go || in_n_value < N_W'(2)) begin
        if ({{(TS_W-N_W){1'b0}}, in_n_value} < TS_W'(TABLE_SIZE)) q_r <= in_n_value;
      end
    end
    if (cmd.init_wr) j_r <= j_r + 1'b1;
    if (cmd.j_set) j_r <= J_W'(i_r);
    if (cmd.j_upd) j_r <= j_r + J_W'(i_r);
    if (cmd.i_inc) i_r <= i_r + 1'b1;
    if (cmd.div_start) f_r <= rdata_r;
    if (cmd.emit) q_r <= div_quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
    if (cmd.emit) begin
      out_pf_r   <= f_r;
      out_last_r <= (div_quo[N_W-1:1] == '0);
    end
  end

  always_comb begin
    sts.in_go     = ({{(TS_W-N_W){1'b0}}, in_n_value} < TS_W'(TABLE_SIZE)) &&
                    (in_n_value >= N_W'(2));
    sts.j_eq_n    = (j_r == {1'b0, n_r});
    sts.i_sq_gt_n = ({{(2*N_W-2*I_W){1'b0}}, i_sq} > {{N_W{1'b0}}, n_r});
    sts.i_prime   = (rdata_r == N_W'(i_r));
    sts.j_gt_n    = (j_r > {1'b0, n_r});
    sts.div_done  = div_done;
    sts.q_le1     = (div_quo[N_W-1:1] == '0);
  end

  assign out_valid        = out_valid_r;
  assign out_prime_factor = out_pf_r;
  assign out_last_factor  = out_last_r;

  a_factor_ge2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pf_r >= N_W'(2))
    else $error("factor word below two");

  a_exact_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> div_rem == '0)
    else $error("table entry does not divide quotient");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> j_r <= {1'b0, n_r})
    else $error("table write beyond n");

endmodule

FILE: sv/smallest_factor_sieve_factorizer_unit.sv
`timescale 1ns / 1ps
// Smallest-prime-factor sieve factorizer, top level.
// Depends on sfsf_pkg, sfsf_ctrl, sfsf_datapath (which holds sfsf_divider).
//
// Usage:
//   Drive in_n_value and raise start; the word is taken on an edge where
//   start is high and busy is low. busy stays high until the item is done.
//   Each prime factor leaves as one word on out_prime_factor, ascending and
//   repeated by multiplicity, with out_valid high for exactly one cycle;
//   out_last_factor marks the final word. Values 0 and 1, and values not
//   below TABLE_SIZE, give no words and leave busy low.
// Sequence, for an accepted n >= 2:
//   table fill, one write per cycle on the single table port; sieve: for
//   each candidate i with i*i <= n, a read and a primality check, plus for
//   each multiple j of each prime i a read, then a conditional write; then
//   per factor a table read, divider start, division and done, and emit.
//   The last word is on the outputs in the first cycle with busy low.
// Reset clears the controller, divider control and output strobe; the table
// needs no clearing since every entry read has been written for that item.
// The receiver cannot stall; out_valid is a one-cycle strobe.
module smallest_factor_sieve_factorizer_unit #(
  parameter int TABLE_SIZE = 65536
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [sfsf_pkg::N_W-1:0] in_n_value,
  output logic                     out_valid,
  output logic [sfsf_pkg::N_W-1:0] out_prime_factor,
  output logic                     out_last_factor
);
  import sfsf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sfsf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  sfsf_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_n_value       (in_n_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_prime_factor (out_prime_factor),
    .out_last_factor  (out_last_factor)
  );

endmodule
